// ----- rtl/core/ihexe_pkg.sv -----
// Shared types, constants and character helpers for the Intel HEX record encoder.
// No dependencies; the top level, ihexe_ctrl and ihexe_dp import this package.
package ihexe_pkg;

   localparam int MAX_RECORD_BYTES = 16;
   localparam int BUF_IDX_W        = $clog2(MAX_RECORD_BYTES);
   localparam int COUNT_W          = 5;
   localparam int POS_W            = 6;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;

   localparam logic [COUNT_W-1:0] RESET_RECORD_LENGTH = 5'd4;
   localparam logic [COUNT_W-1:0] MAX_LEN             = 5'd16;
   localparam logic [0:0]         REG_RECORD_LENGTH   = 1'b0;

   localparam logic [7:0] CHAR_COLON    = 8'h3A;
   localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [7:0] REC_TYPE_DATA = 8'h00;
   localparam logic [POS_W-1:0] EOR_LAST_POS = 6'd11;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_REC  = 3'b010,
      S_EOR  = 3'b100
   } state_type;

   typedef struct packed {
      logic accept;
      logic emit_rec;
      logic emit_eor;
      logic clear_pos;
   } ctrl_cmd_type;

   typedef struct packed {
      logic item_emits;
      logic out_free;
      logic rec_final;
      logic eor_final;
      logic eos_pending;
   } dp_status_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      logic [7:0] wide;
      wide = {4'h0, nibble};
      hex_char = (nibble < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
   endfunction

   // end record ":00000001FF" and newline
   function automatic logic [7:0] eor_char(input logic [3:0] idx);
      case (idx)
         4'd0:    eor_char = CHAR_COLON;
         4'd8:    eor_char = 8'h31;
         4'd9:    eor_char = 8'h46;
         4'd10:   eor_char = 8'h46;
         4'd11:   eor_char = CHAR_NEWLINE;
         default: eor_char = 8'h30;
      endcase
   endfunction

endpackage

// ----- rtl/core/ihexe_if.sv -----
// Request and response channel interfaces of the Intel HEX record encoder.
// Depends on nothing; used by the top level and its environment.
interface ihexe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;

   modport source(output valid, data_byte, end_of_stream, input ready);
   modport sink(input valid, data_byte, end_of_stream, output ready);
endinterface

interface ihexe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] ascii_char;
   logic       last_char;

   modport source(output valid, ascii_char, last_char, input ready);
   modport sink(input valid, ascii_char, last_char, output ready);
endinterface

// ----- rtl/core/intel_hex_record_encoder_core.sv -----
// Top level of the Intel HEX record encoder: channels, length register, ctrl and datapath.
// Depends on ihexe_pkg, ihexe_if, ihexe_ctrl and ihexe_dp.
//
//   channel  direction  handshake      payload
//   req_if   in         valid/ready    data_byte[7:0], end_of_stream
//   rsp_if   out        valid/ready    ascii_char[7:0], last_char
//   csr_*    in         APB write/read record_length[4:0] at any address with paddr[2] low
//
// A request is taken only while no record is being emitted.
// A request that completes a record emits 2*count+12 characters, one per cycle, from the
// character serializer; end of stream adds 12 more for the end record.
// A stalled response holds the serializer; one output register decouples the two sides.
// Synchronous reset clears the record state and sets record_length to 4.
module intel_hex_record_encoder_core
   import ihexe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ihexe_req_if.sink             req_if,
   ihexe_rsp_if.source           rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [COUNT_W-1:0] record_length_ff, record_length_in;
   logic [COUNT_W-1:0] len_eff;
   logic               csr_hit;
   ctrl_cmd_type       cmd;
   dp_status_type      status;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == REG_RECORD_LENGTH);

   always_comb begin
      record_length_in = record_length_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         record_length_in = csr_pwdata[COUNT_W-1:0];
      end
      csr_prdata = csr_hit ? {{(CSR_DATA_W-COUNT_W){1'b0}}, record_length_ff} : '0;
      if (record_length_ff == '0) begin
         len_eff = 5'd1;
      end else if (record_length_ff > MAX_LEN) begin
         len_eff = MAX_LEN;
      end else begin
         len_eff = record_length_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         record_length_ff <= RESET_RECORD_LENGTH;
      end else begin
         record_length_ff <= record_length_in;
      end
   end

   ihexe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ihexe_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .record_len    (len_eff),
      .data_byte     (req_if.data_byte),
      .end_of_stream (req_if.end_of_stream),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .ascii_char    (rsp_if.ascii_char),
      .last_char     (rsp_if.last_char)
   );

endmodule

// ----- rtl/core/ihexe_ctrl.sv -----
// Controller state machine of the Intel HEX record encoder.
// Depends on ihexe_pkg; drives commands to and reads status from ihexe_dp.
module ihexe_ctrl
   import ihexe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.item_emits) begin
                  state_in = S_REC;
               end
            end
         end
         S_REC: begin
            if (status.out_free) begin
               cmd.emit_rec = 1'b1;
               if (status.rec_final) begin
                  cmd.clear_pos = 1'b1;
                  state_in      = status.eos_pending ? S_EOR : S_IDLE;
               end
            end
         end
         S_EOR: begin
            if (status.out_free) begin
               cmd.emit_eor = 1'b1;
               if (status.eor_final) begin
                  cmd.clear_pos = 1'b1;
                  state_in      = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_eor_needs_eos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EOR) |-> status.eos_pending)
      else $error("end record emitted without end of stream");

   a_rec_exit: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_rec && status.rec_final) |=> (state_ff == S_EOR || state_ff == S_IDLE))
      else $error("record did not terminate");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");
`endif

endmodule

// ----- rtl/core/ihexe_dp.sv -----
// Datapath of the Intel HEX record encoder: byte buffer, record state, character output.
// Depends on ihexe_pkg; steered by ihexe_ctrl.
module ihexe_dp
   import ihexe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [COUNT_W-1:0] record_len,
   input  logic [7:0]         data_byte,
   input  logic               end_of_stream,
   input  ctrl_cmd_type       cmd,
   output dp_status_type      status,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         ascii_char,
   output logic               last_char
);

   logic [7:0]         buf_ff [MAX_RECORD_BYTES];
   logic [COUNT_W-1:0] fill_ff, fill_in;
   logic [15:0]        addr_ff, addr_in;
   logic [7:0]         sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff;
   logic [15:0]        rec_addr_ff;
   logic [7:0]         cks_ff;
   logic               eos_ff;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_char_ff, out_char_in;
   logic               out_last_ff, out_last_in;

   logic [COUNT_W-1:0] fill_new;
   logic               full;
   logic [7:0]         sum_new;
   logic [15:0]        rec_addr_new;
   logic [7:0]         cks_new;
   logic [POS_W-1:0]   hp;
   logic [4:0]         byte_idx;
   logic [4:0]         buf_sel;
   logic [7:0]         sel_byte;
   logic [3:0]         nibble;
   logic [7:0]         rec_char;
   logic [POS_W-1:0]   rec_last_pos;

   always_comb begin
      fill_new     = fill_ff + 5'd1;
      full         = (fill_new >= record_len);
      sum_new      = sum_ff + data_byte;
      rec_addr_new = full ? addr_ff : 16'h0000;
      cks_new      = 8'h00 - ({3'b000, fill_new} + rec_addr_new[15:8]
                              + rec_addr_new[7:0] + REC_TYPE_DATA + sum_new);

      fill_in = fill_ff;
      sum_in  = sum_ff;
      addr_in = addr_ff;
      if (cmd.accept) begin
         fill_in = (full || end_of_stream) ? '0 : fill_new;
         sum_in  = (full || end_of_stream) ? 8'h00 : sum_new;
         if (end_of_stream) begin
            addr_in = 16'h0000;
         end else if (full) begin
            addr_in = addr_ff + 16'd1;
         end
      end
   end

   // character of the data record at the current position
   always_comb begin
      rec_last_pos = {count_ff, 1'b0} + 6'd11;
      hp           = pos_ff - 6'd1;
      byte_idx     = hp[5:1];
      buf_sel      = count_ff + 5'd3 - byte_idx;
      if (byte_idx == 5'd0) begin
         sel_byte = {3'b000, count_ff};
      end else if (byte_idx == 5'd1) begin
         sel_byte = rec_addr_ff[15:8];
      end else if (byte_idx == 5'd2) begin
         sel_byte = rec_addr_ff[7:0];
      end else if (byte_idx == 5'd3) begin
         sel_byte = REC_TYPE_DATA;
      end else if (byte_idx == count_ff + 5'd4) begin
         sel_byte = cks_ff;
      end else begin
         sel_byte = buf_ff[buf_sel[BUF_IDX_W-1:0]];
      end
      nibble = hp[0] ? sel_byte[3:0] : sel_byte[7:4];
      if (pos_ff == '0) begin
         rec_char = CHAR_COLON;
      end else if (pos_ff == rec_last_pos) begin
         rec_char = CHAR_NEWLINE;
      end else begin
         rec_char = hex_char(nibble);
      end
   end

   always_comb begin
      status.item_emits  = full || end_of_stream;
      status.out_free    = !out_valid_ff || rsp_ready;
      status.rec_final   = (pos_ff == rec_last_pos);
      status.eor_final   = (pos_ff == EOR_LAST_POS);
      status.eos_pending = eos_ff;

      pos_in = pos_ff;
      if (cmd.accept || cmd.clear_pos) begin
         pos_in = '0;
      end else if (cmd.emit_rec || cmd.emit_eor) begin
         pos_in = pos_ff + 6'd1;
      end

      out_valid_in = out_valid_ff && !rsp_ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit_rec) begin
         out_valid_in = 1'b1;
         out_char_in  = rec_char;
         out_last_in  = status.rec_final && !eos_ff;
      end else if (cmd.emit_eor) begin
         out_valid_in = 1'b1;
         out_char_in  = eor_char(pos_ff[3:0]);
         out_last_in  = status.eor_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         sum_ff       <= 8'h00;
         addr_ff      <= 16'h0000;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         addr_ff      <= addr_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         buf_ff[fill_ff[BUF_IDX_W-1:0]] <= data_byte;
         count_ff    <= fill_new;
         rec_addr_ff <= rec_addr_new;
         cks_ff      <= cks_new;
         eos_ff      <= end_of_stream;
      end
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign ascii_char = out_char_ff;
   assign last_char  = out_last_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff < MAX_LEN)
      else $error("fill count reached a full record without emitting");

   a_pos_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (pos_ff == '0))
      else $error("position not cleared on request");

   a_last_rec: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_rec && status.rec_final && !eos_ff) |=> (rsp_valid && last_char))
      else $error("record newline not marked last");
`endif

endmodule
